// ----- sv/tpl_pkg.sv -----
// Shared types, codes and constants for the two-post lift sequencer.
`timescale 1ns / 1ps

package tpl_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned DELAY_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DELAY_W-1:0] MAGNET_DELAY_RST = 16'd200;
	localparam logic [DELAY_W-1:0] MOTOR_HOLD_RST   = 16'd2000;

	typedef enum logic [1:0] {
		CMD_POLL  = 2'd0,
		CMD_ESTOP = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGNET_DELAY = 2'd0,
		CFG_MOTOR_HOLD   = 2'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RISING   = 3'd1,
		PH_DOWN1    = 3'd2,
		PH_DOWN2    = 3'd3,
		PH_FORCED   = 3'd4,
		PH_DROPPING = 3'd5,
		PH_LOCKED   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_RISING   = 2'd1,
		MODE_DROPPING = 2'd2,
		MODE_LOCKED   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		LOG_NONE         = 4'd0,
		LOG_UP_START     = 4'd1,
		LOG_UP_LIMIT     = 4'd2,
		LOG_UP_RELEASE   = 4'd3,
		LOG_DOWN_START   = 4'd4,
		LOG_DOWN_LIMIT   = 4'd5,
		LOG_DOWN_RELEASE = 4'd6,
		LOG_LOCK_START   = 4'd7,
		LOG_LOCK_STOP    = 4'd8
	} log_t;

	// drive bit positions
	localparam int unsigned DRV_MOTOR  = 0;
	localparam int unsigned DRV_MAGNET = 1;
	localparam int unsigned DRV_DROP   = 2;

	// button bit positions
	localparam int unsigned BTN_UP   = 0;
	localparam int unsigned BTN_DOWN = 1;
	localparam int unsigned BTN_LOCK = 2;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] now_ms;
		logic              up_button;
		logic              down_button;
		logic              lock_button;
		logic              top_limit;
	} in_word_t;

	typedef struct packed {
		logic               motor_on;
		logic               magnet_on;
		logic               drop_valve_on;
		logic [2:0]         sub_state;
		logic [1:0]         lift_mode;
		logic [3:0]         first_log;
		logic [3:0]         second_log;
		logic [DELAY_W-1:0] log_duration;
		logic               count_descent;
		logic               count_lock;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [DELAY_W-1:0]   data;
	} cfg_word_t;

	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] action_start;
		logic [2:0]        last_buttons;
		logic [2:0]        drive;
		mode_t             mode;
	} lift_state_t;

endpackage

// ----- sv/tpl_ifs.sv -----
// Valid/ready channel interfaces for poll input, result output and config writes.
`timescale 1ns / 1ps

interface tpl_in_if import tpl_pkg::*;;
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tpl_out_if import tpl_pkg::*;;
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tpl_cfg_if import tpl_pkg::*;;
	logic      valid;
	logic      ready;
	cfg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tpl_step.sv -----
// Next-state and result logic for one poll word of the lift sequencer.
`timescale 1ns / 1ps

module tpl_step import tpl_pkg::*; (
	input  lift_state_t        st,
	input  logic [DELAY_W-1:0] magnet_delay,
	input  logic [DELAY_W-1:0] motor_hold,
	input  in_word_t           word,
	output lift_state_t        nxt,
	output out_word_t          res
);

	logic [TIME_W-1:0]  elapsed;
	log_t               log1;
	log_t               log2;
	logic [DELAY_W-1:0] dur;
	logic               cnt_down;
	logic               cnt_lock;
	logic [2:0]         btn;

	assign elapsed = word.now_ms - st.action_start;
	assign btn     = {word.lock_button, word.down_button, word.up_button};

	always_comb begin
		nxt      = st;
		log1     = LOG_NONE;
		log2     = LOG_NONE;
		dur      = '0;
		cnt_down = 1'b0;
		cnt_lock = 1'b0;
		unique case (cmd_t'(word.command))
			CMD_ESTOP: begin
				nxt.drive = '0;
				nxt.phase = PH_IDLE;
			end
			CMD_CLEAR: begin
				nxt.phase = PH_IDLE;
			end
			CMD_POLL: begin
				unique case (st.phase)
					PH_IDLE: begin
						if (word.up_button && !st.last_buttons[BTN_UP]) begin
							nxt.drive        = '0;
							nxt.drive[DRV_MOTOR] = 1'b1;
							nxt.action_start = word.now_ms;
							nxt.phase        = PH_RISING;
							nxt.mode         = MODE_RISING;
							log1             = LOG_UP_START;
						end else if (word.down_button && !st.last_buttons[BTN_DOWN]) begin
							nxt.drive[DRV_MOTOR] = 1'b1;
							nxt.action_start = word.now_ms;
							nxt.phase        = PH_DOWN1;
							nxt.mode         = MODE_DROPPING;
							log1             = LOG_DOWN_START;
							cnt_down         = 1'b1;
						end else if (word.lock_button && !st.last_buttons[BTN_LOCK]) begin
							nxt.drive[DRV_DROP] = 1'b1;
							nxt.action_start = word.now_ms;
							nxt.phase        = PH_LOCKED;
							nxt.mode         = MODE_LOCKED;
							log1             = LOG_LOCK_START;
							cnt_lock         = 1'b1;
						end
					end
					PH_RISING: begin
						nxt.drive[DRV_MAGNET] = 1'b0;
						nxt.drive[DRV_DROP]   = 1'b0;
						if (word.top_limit || !word.up_button) begin
							dur       = elapsed[DELAY_W-1:0];
							nxt.drive = '0;
							nxt.phase = PH_IDLE;
							nxt.mode  = MODE_IDLE;
							log1      = word.top_limit ? LOG_UP_LIMIT : LOG_UP_RELEASE;
						end
					end
					PH_DOWN1, PH_DOWN2, PH_FORCED, PH_DROPPING: begin
						// timed step, then forced unlock, then release, all in one poll
						if (st.phase == PH_DOWN1) begin
							if (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, magnet_delay}) begin
								nxt.drive[DRV_MAGNET] = 1'b1;
								nxt.phase = PH_DOWN2;
							end
						end else if (st.phase == PH_DOWN2 || st.phase == PH_FORCED) begin
							if (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, motor_hold}) begin
								nxt.drive[DRV_MOTOR] = 1'b0;
								nxt.drive[DRV_DROP]  = 1'b1;
								nxt.phase = PH_DROPPING;
							end
						end
						if (nxt.phase != PH_DROPPING && nxt.phase != PH_FORCED &&
						    (word.top_limit || word.lock_button)) begin
							nxt.drive[DRV_MOTOR]  = 1'b0;
							nxt.drive[DRV_MAGNET] = 1'b1;
							nxt.phase = PH_FORCED;
							nxt.mode  = MODE_DROPPING;
							log1      = LOG_DOWN_LIMIT;
							dur       = elapsed[DELAY_W-1:0];
						end
						if (!word.down_button) begin
							dur       = elapsed[DELAY_W-1:0];
							nxt.drive = '0;
							nxt.phase = PH_IDLE;
							nxt.mode  = MODE_IDLE;
							if (log1 == LOG_NONE) begin
								log1 = LOG_DOWN_RELEASE;
							end else begin
								log2 = LOG_DOWN_RELEASE;
							end
						end
					end
					PH_LOCKED: begin
						if (!word.lock_button) begin
							dur       = elapsed[DELAY_W-1:0];
							nxt.drive = '0;
							nxt.phase = PH_IDLE;
							nxt.mode  = MODE_IDLE;
							log1      = LOG_LOCK_STOP;
						end
					end
					default: begin
						nxt.phase = PH_IDLE;
					end
				endcase
				nxt.last_buttons = btn;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.motor_on      = nxt.drive[DRV_MOTOR];
		res.magnet_on     = nxt.drive[DRV_MAGNET];
		res.drop_valve_on = nxt.drive[DRV_DROP];
		res.sub_state     = nxt.phase;
		res.lift_mode     = nxt.mode;
		res.first_log     = log1;
		res.second_log    = log2;
		res.log_duration  = dur;
		res.count_descent = cnt_down;
		res.count_lock    = cnt_lock;
	end

endmodule

// ----- sv/two_post_lift_sequencer.sv -----
// Top level of the two-post lift sequencer: input stage, state, result register, config.
//
//   channel  dir  word        accepted when
//   poll     in   in_word_t   poll.valid && poll.ready
//   result   out  out_word_t  result.valid && result.ready
//   cfg      in   cfg_word_t  cfg.valid && cfg.ready (ready always high)
//
// One poll word per cycle sustained while the result is taken; each word passes
// through the input register, then the step logic into the result register.
// State advances when the input register moves into the result register.
// A stalled result holds; one more word waits in the input register.
// arst_n clears state, config to reset values, and both valid flags.
`timescale 1ns / 1ps

module two_post_lift_sequencer import tpl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tpl_in_if.sink    poll,
	tpl_out_if.source result,
	tpl_cfg_if.sink   cfg
);

	logic               in_valid_s1;
	in_word_t           in_word_s1;
	logic               out_valid_q;
	out_word_t          out_word_q;
	lift_state_t        state_q;
	lift_state_t        state_nxt;
	out_word_t          res_nxt;
	logic [DELAY_W-1:0] magnet_delay_q;
	logic [DELAY_W-1:0] motor_hold_q;
	logic               adv;

	assign adv          = in_valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready   = !in_valid_s1 || adv;
	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			in_valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			in_word_s1 <= poll.data;
		end
	end

	tpl_step u_step (
		.st           (state_q),
		.magnet_delay (magnet_delay_q),
		.motor_hold   (motor_hold_q),
		.word         (in_word_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.action_start <= '0;
			state_q.last_buttons <= '0;
			state_q.drive        <= '0;
			state_q.mode         <= MODE_IDLE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnet_delay_q <= MAGNET_DELAY_RST;
			motor_hold_q   <= MOTOR_HOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.data.index))
				CFG_MAGNET_DELAY: magnet_delay_q <= cfg.data.data;
				CFG_MOTOR_HOLD:   motor_hold_q   <= cfg.data.data;
				default: begin
				end
			endcase
		end
	end

	// input side only stalls when both stages are full and the result is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!poll.ready |-> (in_valid_s1 && out_valid_q && !result.ready))
		else $error("poll stalled with a free stage");

	// locked phase always keeps the drop valve open
	a_lock_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_LOCKED) |-> state_q.drive[DRV_DROP])
		else $error("locked without drop valve");

	a_descent_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.count_descent) |->
		(out_word_q.sub_state == PH_DOWN1 && out_word_q.lift_mode == MODE_DROPPING &&
		 out_word_q.first_log == LOG_DOWN_START))
		else $error("descent pulse without descent start");

	a_second_log: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.second_log != LOG_NONE) |->
		(out_word_q.first_log == LOG_DOWN_LIMIT && out_word_q.sub_state == PH_IDLE))
		else $error("second event without forced unlock and release");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(out_word_q)))
		else $error("held result changed");

endmodule

// ----- tb/sv/two_post_lift_sequencer_test.sv -----
// Self-checking testbench for the two-post lift sequencer: directed and random polls.
`timescale 1ns / 1ps

module two_post_lift_sequencer_test;
	import tpl_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned IDLE_PCT = 23;
	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned SQUEEZE_CYCLES = 80;
	localparam int unsigned ITEMS_PER_SETTING = 140;
	localparam int unsigned SETTLE_CYCLES = 4;

	class lift_ledger;
		logic [DELAY_W-1:0] magnet_delay;
		logic [DELAY_W-1:0] motor_hold;
		phase_t ph;
		logic [TIME_W-1:0] start;
		logic [2:0] last_btn;
		logic [2:0] drv;
		mode_t mode;
		out_word_t owed_results[$];
		int unsigned errors;

		function new();
			magnet_delay = MAGNET_DELAY_RST;
			motor_hold = MOTOR_HOLD_RST;
			ph = PH_IDLE;
			start = '0;
			last_btn = '0;
			drv = '0;
			mode = MODE_IDLE;
			errors = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] val);
			if (idx == CFG_MAGNET_DELAY)
				magnet_delay = val;
			else if (idx == CFG_MOTOR_HOLD)
				motor_hold = val;
		endfunction

		function void halt();
			drv = '0;
			ph = PH_IDLE;
			mode = MODE_IDLE;
		endfunction

		function void note_poll(in_word_t w);
			out_word_t r;
			logic [TIME_W-1:0] elapsed;
			log_t l1;
			log_t l2;
			logic [DELAY_W-1:0] dur;
			logic cnt_dn;
			logic cnt_lk;
			l1 = LOG_NONE;
			l2 = LOG_NONE;
			dur = '0;
			cnt_dn = 1'b0;
			cnt_lk = 1'b0;
			elapsed = w.now_ms - start;
			if (w.command == CMD_ESTOP) begin
				drv = '0;
				ph = PH_IDLE;
			end else if (w.command == CMD_CLEAR) begin
				ph = PH_IDLE;
			end else if (w.command == CMD_POLL) begin
				case (ph)
					PH_IDLE: begin
						if (w.up_button && !last_btn[BTN_UP]) begin
							drv = '0;
							drv[DRV_MOTOR] = 1'b1;
							start = w.now_ms;
							ph = PH_RISING;
							mode = MODE_RISING;
							l1 = LOG_UP_START;
						end else if (w.down_button && !last_btn[BTN_DOWN]) begin
							drv[DRV_MOTOR] = 1'b1;
							start = w.now_ms;
							ph = PH_DOWN1;
							mode = MODE_DROPPING;
							l1 = LOG_DOWN_START;
							cnt_dn = 1'b1;
						end else if (w.lock_button && !last_btn[BTN_LOCK]) begin
							drv[DRV_DROP] = 1'b1;
							start = w.now_ms;
							ph = PH_LOCKED;
							mode = MODE_LOCKED;
							l1 = LOG_LOCK_START;
							cnt_lk = 1'b1;
						end
					end
					PH_RISING: begin
						drv[DRV_MAGNET] = 1'b0;
						drv[DRV_DROP] = 1'b0;
						if (w.top_limit) begin
							dur = elapsed[DELAY_W-1:0];
							halt();
							l1 = LOG_UP_LIMIT;
						end else if (!w.up_button) begin
							dur = elapsed[DELAY_W-1:0];
							halt();
							l1 = LOG_UP_RELEASE;
						end
					end
					PH_DOWN1, PH_DOWN2, PH_FORCED, PH_DROPPING: begin
						if (ph == PH_DOWN1) begin
							if (elapsed >= TIME_W'(magnet_delay)) begin
								drv[DRV_MAGNET] = 1'b1;
								ph = PH_DOWN2;
							end
						end else if (ph == PH_DOWN2 || ph == PH_FORCED) begin
							if (elapsed >= TIME_W'(motor_hold)) begin
								drv[DRV_MOTOR] = 1'b0;
								drv[DRV_DROP] = 1'b1;
								ph = PH_DROPPING;
							end
						end
						if (ph != PH_DROPPING && ph != PH_FORCED &&
						    (w.top_limit || w.lock_button)) begin
							drv[DRV_MOTOR] = 1'b0;
							drv[DRV_MAGNET] = 1'b1;
							ph = PH_FORCED;
							mode = MODE_DROPPING;
							l1 = LOG_DOWN_LIMIT;
							dur = elapsed[DELAY_W-1:0];
						end
						if (!w.down_button) begin
							dur = elapsed[DELAY_W-1:0];
							halt();
							if (l1 == LOG_NONE)
								l1 = LOG_DOWN_RELEASE;
							else
								l2 = LOG_DOWN_RELEASE;
						end
					end
					PH_LOCKED: begin
						if (!w.lock_button) begin
							dur = elapsed[DELAY_W-1:0];
							halt();
							l1 = LOG_LOCK_STOP;
						end
					end
					default: ph = PH_IDLE;
				endcase
				last_btn[BTN_UP] = w.up_button;
				last_btn[BTN_DOWN] = w.down_button;
				last_btn[BTN_LOCK] = w.lock_button;
			end
			r.motor_on = drv[DRV_MOTOR];
			r.magnet_on = drv[DRV_MAGNET];
			r.drop_valve_on = drv[DRV_DROP];
			r.sub_state = ph;
			r.lift_mode = mode;
			r.first_log = l1;
			r.second_log = l2;
			r.log_duration = dur;
			r.count_descent = cnt_dn;
			r.count_lock = cnt_lk;
			owed_results.push_back(r);
		endfunction

		function string diff(string field, longint unsigned got, longint unsigned want);
			return $sformatf("%s got %0d, want %0d", field, got, want);
		endfunction

		task check_result(out_word_t got);
			out_word_t want;
			if (owed_results.size() == 0) begin
				report($sformatf("result word with none owed: %p", got));
				return;
			end
			want = owed_results.pop_front();
			if (got.motor_on !== want.motor_on)
				report(diff("motor_on", got.motor_on, want.motor_on));
			if (got.magnet_on !== want.magnet_on)
				report(diff("magnet_on", got.magnet_on, want.magnet_on));
			if (got.drop_valve_on !== want.drop_valve_on)
				report(diff("drop_valve_on", got.drop_valve_on, want.drop_valve_on));
			if (got.sub_state !== want.sub_state)
				report(diff("sub_state", got.sub_state, want.sub_state));
			if (got.lift_mode !== want.lift_mode)
				report(diff("lift_mode", got.lift_mode, want.lift_mode));
			if (got.first_log !== want.first_log)
				report(diff("first_log", got.first_log, want.first_log));
			if (got.second_log !== want.second_log)
				report(diff("second_log", got.second_log, want.second_log));
			if (got.log_duration !== want.log_duration)
				report(diff("log_duration", got.log_duration, want.log_duration));
			if (got.count_descent !== want.count_descent)
				report(diff("count_descent", got.count_descent, want.count_descent));
			if (got.count_lock !== want.count_lock)
				report(diff("count_lock", got.count_lock, want.count_lock));
		endtask
	endclass

	logic clk;
	logic arst_n;

	tpl_in_if poll_ch();
	tpl_out_if res_ch();
	tpl_cfg_if cfg_ch();

	two_post_lift_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll(poll_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	lift_ledger sb;
	bit sender_gaps;
	bit recv_gaps;
	bit squeeze_req;
	int unsigned items_sent;
	int unsigned quiet;
	logic [TIME_W-1:0] wall_ms;
	logic [DELAY_W-1:0] cur_delay;
	logic [DELAY_W-1:0] cur_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				res_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_req = 1'b0;
			end
			res_ch.ready <= !(recv_gaps && $urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (poll_ch.valid && poll_ch.ready)
				sb.note_poll(poll_ch.data);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.data);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.data.index, cfg_ch.data.data);
			if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	function in_word_t poll_word(logic [1:0] cmd, bit up, bit dn, bit lk, bit lim);
		in_word_t w;
		w.command = cmd;
		w.now_ms = wall_ms;
		w.up_button = up;
		w.down_button = dn;
		w.lock_button = lk;
		w.top_limit = lim;
		return w;
	endfunction

	task send_poll(in_word_t w);
		while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
			poll_ch.valid <= 1'b0;
			@(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.data <= w;
		do @(posedge clk); while (!poll_ch.ready);
		if (w.command != CMD_UNUSED)
			items_sent++;
	endtask

	task poll_at(int unsigned adv, bit up, bit dn, bit lk, bit lim);
		wall_ms += adv;
		send_poll(poll_word(CMD_POLL, up, dn, lk, lim));
	endtask

	task set_delays(logic [DELAY_W-1:0] delay_ms, logic [DELAY_W-1:0] hold_ms);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: CFG_MAGNET_DELAY, data: delay_ms};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.data <= '{index: CFG_MOTOR_HOLD, data: hold_ms};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_delay = delay_ms;
		cur_hold = hold_ms;
	endtask

	task drain();
		poll_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.owed_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task step_time();
		int unsigned r;
		int unsigned span;
		span = ((cur_hold > cur_delay) ? cur_hold : cur_delay) / 3 + 8;
		r = $urandom_range(99);
		if (r < 8)
			wall_ms = $urandom;
		else if (r < 40)
			wall_ms += $urandom_range(0, 20);
		else
			wall_ms += $urandom_range(0, span);
	endtask

	task send_odd_command();
		int unsigned r;
		logic [1:0] cmd;
		r = $urandom_range(2);
		cmd = (r == 0) ? CMD_ESTOP : (r == 1) ? CMD_CLEAR : CMD_UNUSED;
		send_poll(poll_word(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1))));
	endtask

	// release, press one button, hold with random disturbances, release
	task lift_sequence();
		int unsigned which;
		int unsigned holds;
		bit up;
		bit dn;
		bit lk;
		which = $urandom_range(2);
		holds = $urandom_range(1, 8);
		step_time();
		send_poll(poll_word(CMD_POLL, 0, 0, 0, 1'($urandom_range(1))));
		up = (which == 0) || ($urandom_range(9) == 0);
		dn = (which == 1) || ($urandom_range(9) == 0);
		lk = (which == 2) || ($urandom_range(9) == 0);
		step_time();
		send_poll(poll_word(CMD_POLL, up, dn, lk, $urandom_range(19) == 0));
		repeat (holds) begin
			step_time();
			if ($urandom_range(99) < 6)
				send_odd_command();
			else
				send_poll(poll_word(CMD_POLL,
					(which == 0) || ($urandom_range(9) == 0),
					(which == 1) || ($urandom_range(9) == 0),
					(which == 2) || ($urandom_range(9) == 0),
					$urandom_range(9) == 0));
		end
		step_time();
		send_poll(poll_word(CMD_POLL, 0, 0, $urandom_range(5) == 0,
			1'($urandom_range(1))));
	endtask

	task noise_item();
		step_time();
		send_poll(poll_word(2'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))));
	endtask

	task random_phase(int unsigned n);
		int unsigned first;
		first = items_sent;
		while (items_sent - first < n) begin
			if ($urandom_range(99) < 15)
				noise_item();
			else
				lift_sequence();
		end
	endtask

	task directed();
		wall_ms = '1;
		poll_at(0, 0, 0, 0, 0);
		poll_at(1, 1, 0, 0, 0);      // timestamp wraps to 0
		poll_at(50, 1, 0, 0, 0);
		poll_at(10, 1, 0, 0, 1);     // up stopped by limit
		poll_at(5, 1, 0, 0, 0);
		poll_at(70000, 0, 0, 0, 0);  // gap beyond 16 bits, idle so nothing logged
		poll_at(3, 0, 1, 0, 0);
		poll_at(199, 0, 1, 0, 0);
		poll_at(1, 0, 1, 0, 0);      // magnet on at delay
		poll_at(1800, 0, 1, 0, 1);   // dropping, limit no longer forces
		poll_at(9, 0, 0, 0, 0);
		poll_at(2, 0, 0, 1, 0);
		poll_at(40, 1, 1, 1, 0);
		poll_at(5, 0, 0, 0, 0);
		poll_at(2, 1, 1, 1, 0);      // up has priority
		poll_at(2, 0, 0, 0, 0);
		poll_at(2, 0, 1, 0, 0);
		poll_at(2, 0, 1, 1, 0);      // forced unlock by lock button
		poll_at(2000, 0, 1, 1, 0);   // forced unlock then hold time
		poll_at(2, 0, 0, 0, 0);
		poll_at(2, 0, 1, 0, 0);
		send_poll(poll_word(CMD_ESTOP, 0, 1, 0, 0));
		poll_at(2, 0, 1, 0, 0);      // still held, no new edge
		poll_at(2, 0, 0, 0, 0);
		poll_at(2, 0, 1, 0, 0);
		send_poll(poll_word(CMD_CLEAR, 0, 1, 0, 0));
		poll_at(2, 0, 1, 1, 0);      // lock start keeps motor left on
		send_poll(poll_word(CMD_UNUSED, 1, 1, 1, 1));
		poll_at(2, 0, 0, 0, 0);
		poll_at(2, 0, 1, 0, 0);
		poll_at(300, 0, 0, 0, 1);    // timed step, forced unlock, release at once
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		poll_ch.valid = 1'b0;
		poll_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		sender_gaps = 1'b1;
		recv_gaps = 1'b1;
		squeeze_req = 1'b0;
		items_sent = 0;
		quiet = 0;
		wall_ms = '0;
		cur_delay = MAGNET_DELAY_RST;
		cur_hold = MOTOR_HOLD_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();

		drain();
		set_delays(16'd0, 16'd0);
		squeeze_req = 1'b1;
		random_phase(ITEMS_PER_SETTING);

		drain();
		set_delays(16'hFFFF, 16'hFFFF);
		sender_gaps = 1'b0;
		recv_gaps = 1'b0;
		random_phase(ITEMS_PER_SETTING);
		sender_gaps = 1'b1;
		recv_gaps = 1'b1;

		drain();
		set_delays(MAGNET_DELAY_RST, MOTOR_HOLD_RST);
		random_phase(ITEMS_PER_SETTING);

		drain();
		set_delays(DELAY_W'($urandom_range(0, 5000)), DELAY_W'($urandom_range(0, 5000)));
		random_phase(ITEMS_PER_SETTING);

		drain();
		set_delays(16'd3000, 16'd1000);  // hold shorter than magnet delay
		random_phase(ITEMS_PER_SETTING);

		drain();
		if (sb.owed_results.size() != 0)
			sb.report($sformatf("%0d result words never arrived", sb.owed_results.size()));
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
